/* hdl/tra_pkg.sv */
package tra_pkg;

  localparam int PXW = 7;
  localparam int VW = 12;
  localparam int CW = VW + 1;
  localparam int RW = 2 * PXW;
  localparam int CNTW = 13;
  localparam int OPW = 2;
  localparam int COLW = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW = 7;

  localparam int MAX_WIDTH_DEF = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int SUBPIXEL_BITS_DEF = 4;

  localparam logic [PXW-1:0] IMAGE_WIDTH_RST = 7'd16;
  localparam logic [PXW-1:0] IMAGE_HEIGHT_RST = 7'd8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [OPW-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPW-1:0] OP_DRAW = 2'd1;
  localparam logic [OPW-1:0] OP_READ = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_AREA  = 2'd1,
    PH_EDGE  = 2'd2,
    PH_COLOR = 2'd3
  } mac_ph_t;

  typedef struct packed {
    logic    load;
    logic    clr_init;
    logic    clr_wr;
    logic    rd_issue;
    logic    box_init;
    logic    x_step;
    logic    y_step;
    logic    mac_en;
    mac_ph_t ph;
    logic [3:0] step;
    logic    px_read;
    logic    div_init;
    logic    div_en;
    logic    px_write;
    logic    res_load;
  } tra_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic op_draw;
    logic op_read;
    logic clr_empty;
    logic clr_last;
    logic area_zero;
    logic area_neg;
    logic box_empty;
    logic covered;
    logic x_last;
    logic y_last;
  } tra_stat_t;

endpackage

/* hdl/tra_ctrl.sv */
module tra_ctrl import tra_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  tra_stat_t stat,
  output tra_cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_DECODE = 14'b00000000000010,
    S_CLEAR  = 14'b00000000000100,
    S_RWAIT  = 14'b00000000001000,
    S_AREA   = 14'b00000000010000,
    S_TEST   = 14'b00000000100000,
    S_EDGE   = 14'b00000001000000,
    S_CHECK  = 14'b00000010000000,
    S_COLOR  = 14'b00000100000000,
    S_DIVI   = 14'b00001000000000,
    S_DIV    = 14'b00010000000000,
    S_BLEND  = 14'b00100000000000,
    S_NEXT   = 14'b01000000000000,
    S_FIN    = 14'b10000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.step      = step_r;
    in_ready      = 1'b0;
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat.op_clear) begin
          cmd.clr_init = 1'b1;
          state_nxt    = stat.clr_empty ? S_FIN : S_CLEAR;
        end else if (stat.op_read) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_RWAIT;
        end else if (stat.op_draw) begin
          state_nxt = S_AREA;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_FIN;
      end
      S_RWAIT: state_nxt = S_FIN;
      S_AREA: begin
        cmd.mac_en   = 1'b1;
        cmd.ph       = PH_AREA;
        cmd.box_init = (step_r == 4'd0);
        if (step_r == 4'd1) begin
          step_nxt  = '0;
          state_nxt = S_TEST;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      S_TEST: begin
        if (stat.area_zero || stat.area_neg || stat.box_empty) state_nxt = S_FIN;
        else state_nxt = S_EDGE;
      end
      S_EDGE: begin
        cmd.mac_en = 1'b1;
        cmd.ph     = PH_EDGE;
        if (step_r == 4'd5) begin
          step_nxt  = '0;
          state_nxt = S_CHECK;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      S_CHECK: begin
        if (stat.covered) begin
          cmd.px_read = 1'b1;
          state_nxt   = S_COLOR;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_COLOR: begin
        cmd.mac_en = 1'b1;
        cmd.ph     = PH_COLOR;
        if (step_r[1:0] == 2'd2) begin
          if (step_r[3:2] == 2'd3) begin
            step_nxt  = '0;
            state_nxt = S_DIVI;
          end else begin
            step_nxt = {step_r[3:2] + 2'd1, 2'd0};
          end
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        step_nxt     = 4'd7;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        if (step_r[2:0] == 3'd0) state_nxt = S_BLEND;
        else step_nxt = step_r - 4'd1;
      end
      S_BLEND: begin
        cmd.px_write = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_NEXT;
      end
      S_NEXT: begin
        step_nxt = '0;
        if (stat.x_last) begin
          if (stat.y_last) begin
            state_nxt = S_FIN;
          end else begin
            cmd.y_step = 1'b1;
            state_nxt  = S_EDGE;
          end
        end else begin
          cmd.x_step = 1'b1;
          state_nxt  = S_EDGE;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/tra_datapath.sv */
module tra_datapath import tra_pkg::*; #(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = MAX_HEIGHT_DEF,
  parameter int SUBPIXEL_BITS = SUBPIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]     cfg_data,
  input  logic [OPW-1:0]        in_operation,
  input  logic signed [VW-1:0]  in_vertex_a_x,
  input  logic signed [VW-1:0]  in_vertex_a_y,
  input  logic signed [VW-1:0]  in_vertex_b_x,
  input  logic signed [VW-1:0]  in_vertex_b_y,
  input  logic signed [VW-1:0]  in_vertex_c_x,
  input  logic signed [VW-1:0]  in_vertex_c_y,
  input  logic [COLW-1:0]       in_vertex_a_color,
  input  logic [COLW-1:0]       in_vertex_b_color,
  input  logic [COLW-1:0]       in_vertex_c_color,
  input  logic [VW-1:0]         in_pixel_index,
  input  tra_cmd_t              cmd,
  output tra_stat_t             stat,
  output logic [COLW-1:0]       out_pixel_value,
  output logic [CNTW-1:0]       out_pixels_drawn,
  output logic                  out_degenerate
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = ((PXW + SUBPIXEL_BITS) > VW ? PXW + SUBPIXEL_BITS : VW) + 2;
  localparam int EW = CW + SW + 1;
  localparam int PW = CW + EW;
  localparam int ACW = EW + 11;
  localparam int NW = ACW + 1;

  logic [PXW-1:0] img_w_r, img_h_r, w_sat, h_sat;
  logic [RW-1:0]  npix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMAGE_WIDTH_RST;
      img_h_r <= IMAGE_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  img_w_r <= cfg_data;
        REG_IMAGE_HEIGHT: img_h_r <= cfg_data;
      endcase
    end
  end

  assign w_sat = (int'(img_w_r) > MAX_WIDTH) ? PXW'(MAX_WIDTH) : img_w_r;
  assign h_sat = (int'(img_h_r) > MAX_HEIGHT) ? PXW'(MAX_HEIGHT) : img_h_r;
  assign npix  = RW'(w_sat) * RW'(h_sat);

  logic [OPW-1:0]       op_r;
  logic signed [VW-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic [COLW-1:0]      ka_r, kb_r, kc_r;
  logic [VW-1:0]        idx_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      ax_r  <= in_vertex_a_x;
      ay_r  <= in_vertex_a_y;
      bx_r  <= in_vertex_b_x;
      by_r  <= in_vertex_b_y;
      cx_r  <= in_vertex_c_x;
      cy_r  <= in_vertex_c_y;
      ka_r  <= in_vertex_a_color;
      kb_r  <= in_vertex_b_color;
      kc_r  <= in_vertex_c_color;
      idx_r <= in_pixel_index;
    end
  end

  logic signed [CW-1:0] dxab, dyab, dxbc, dybc, dxca, dyca;
  logic                 tl1, tl2, tl3;

  assign dxab = CW'(bx_r) - CW'(ax_r);
  assign dyab = CW'(by_r) - CW'(ay_r);
  assign dxbc = CW'(cx_r) - CW'(bx_r);
  assign dybc = CW'(cy_r) - CW'(by_r);
  assign dxca = CW'(ax_r) - CW'(cx_r);
  assign dyca = CW'(ay_r) - CW'(cy_r);

  assign tl1 = (dyab < 0) || (dyab == 0 && dxab > 0);
  assign tl2 = (dybc < 0) || (dybc == 0 && dxbc > 0);
  assign tl3 = (dyca < 0) || (dyca == 0 && dxca > 0);

  function automatic logic signed [VW-1:0] min3(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b,
                                                input logic signed [VW-1:0] c);
    logic signed [VW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [VW-1:0] max3(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b,
                                                input logic signed [VW-1:0] c);
    logic signed [VW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  logic signed [VW-1:0] fxmin, fxmax, fymin, fymax;
  logic signed [CW-1:0] fxmin_e, fxmax_e, fymin_e, fymax_e;
  logic signed [CW-1:0] wm1, hm1, x0c, x1c, y0c, y1c;

  assign fxmin   = min3(ax_r, bx_r, cx_r) >>> SUBPIXEL_BITS;
  assign fxmax   = max3(ax_r, bx_r, cx_r) >>> SUBPIXEL_BITS;
  assign fymin   = min3(ay_r, by_r, cy_r) >>> SUBPIXEL_BITS;
  assign fymax   = max3(ay_r, by_r, cy_r) >>> SUBPIXEL_BITS;
  assign fxmin_e = CW'(fxmin);
  assign fxmax_e = CW'(fxmax);
  assign fymin_e = CW'(fymin);
  assign fymax_e = CW'(fymax);
  assign wm1     = $signed(CW'(w_sat)) - $signed(CW'(1));
  assign hm1     = $signed(CW'(h_sat)) - $signed(CW'(1));
  assign x0c     = (fxmin_e < 0) ? '0 : fxmin_e;
  assign y0c     = (fymin_e < 0) ? '0 : fymin_e;
  assign x1c     = (fxmax_e > wm1) ? wm1 : fxmax_e;
  assign y1c     = (fymax_e > hm1) ? hm1 : fymax_e;

  logic [PXW-1:0] x_r, y_r, x0_r, x1_r, y1_r;
  logic [AW-1:0]  row_r, addr_r, row_nxt;
  logic [RW-1:0]  row0;

  assign row0    = RW'(y0c[PXW-1:0]) * RW'(w_sat);
  assign row_nxt = row_r + AW'(w_sat);

  always_ff @(posedge clk) begin
    if (cmd.box_init) begin
      x_r    <= x0c[PXW-1:0];
      y_r    <= y0c[PXW-1:0];
      x0_r   <= x0c[PXW-1:0];
      x1_r   <= x1c[PXW-1:0];
      y1_r   <= y1c[PXW-1:0];
      row_r  <= AW'(row0);
      addr_r <= AW'(row0 + RW'(x0c[PXW-1:0]));
    end else if (cmd.x_step) begin
      x_r    <= x_r + PXW'(1);
      addr_r <= addr_r + AW'(1);
    end else if (cmd.y_step) begin
      y_r    <= y_r + PXW'(1);
      x_r    <= x0_r;
      row_r  <= row_nxt;
      addr_r <= row_nxt + AW'(x0_r);
    end
  end

  logic [SW-1:0]        sx_u, sy_u;
  logic signed [SW-1:0] sxa, sya, sxb, syb, sxc, syc;

  assign sx_u = SW'(x_r) << SUBPIXEL_BITS;
  assign sy_u = SW'(y_r) << SUBPIXEL_BITS;
  assign sxa  = $signed(sx_u) - SW'(ax_r);
  assign sya  = $signed(sy_u) - SW'(ay_r);
  assign sxb  = $signed(sx_u) - SW'(bx_r);
  assign syb  = $signed(sy_u) - SW'(by_r);
  assign sxc  = $signed(sx_u) - SW'(cx_r);
  assign syc  = $signed(sy_u) - SW'(cy_r);

  logic signed [EW-1:0]  area_r;
  logic signed [EW-1:0]  e_r [3];
  logic [ACW-1:0]        n_r [4];
  logic signed [ACW-1:0] acc_r, acc_nxt, prod_t;
  logic signed [CW-1:0]  mul_a;
  logic signed [EW-1:0]  mul_b;
  logic signed [PW-1:0]  prod;
  logic                  mul_sub, mac_first;
  logic [1:0]            ch;

  assign ch = cmd.step[3:2];

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_sub   = 1'b0;
    mac_first = 1'b0;
    unique case (cmd.ph)
      PH_IDLE: ;
      PH_AREA: begin
        if (!cmd.step[0]) begin
          mul_a     = dyab;
          mul_b     = EW'(dxca);
          mac_first = 1'b1;
        end else begin
          mul_a   = dxab;
          mul_b   = EW'(dyca);
          mul_sub = 1'b1;
        end
      end
      PH_EDGE: begin
        mac_first = !cmd.step[0];
        mul_sub   = cmd.step[0];
        unique case (cmd.step[2:0])
          3'd0: begin mul_a = dxab; mul_b = EW'(sya); end
          3'd1: begin mul_a = dyab; mul_b = EW'(sxa); end
          3'd2: begin mul_a = dxbc; mul_b = EW'(syb); end
          3'd3: begin mul_a = dybc; mul_b = EW'(sxb); end
          3'd4: begin mul_a = dxca; mul_b = EW'(syc); end
          default: begin mul_a = dyca; mul_b = EW'(sxc); end
        endcase
      end
      PH_COLOR: begin
        unique case (cmd.step[1:0])
          2'd0: begin
            mul_a     = $signed(CW'(ka_r[8*ch +: 8]));
            mul_b     = e_r[1];
            mac_first = 1'b1;
          end
          2'd1: begin
            mul_a = $signed(CW'(kb_r[8*ch +: 8]));
            mul_b = e_r[2];
          end
          default: begin
            mul_a = $signed(CW'(kc_r[8*ch +: 8]));
            mul_b = e_r[0];
          end
        endcase
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_t  = prod[ACW-1:0];
  assign acc_nxt = (mac_first ? '0 : acc_r) + (mul_sub ? -prod_t : prod_t);

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      acc_r <= acc_nxt;
      if (cmd.ph == PH_AREA && cmd.step[0]) area_r <= acc_nxt[EW-1:0];
      if (cmd.ph == PH_EDGE && cmd.step[0]) e_r[cmd.step[2:1]] <= acc_nxt[EW-1:0];
      if (cmd.ph == PH_COLOR && cmd.step[1:0] == 2'd2) n_r[ch] <= acc_nxt;
    end
  end

  logic [NW-1:0] dsor, dsh;
  logic [NW-1:0] rem_r [4];
  logic [NW-1:0] rem_nxt [4];
  logic [7:0]    q_r [4];
  logic [7:0]    q_nxt [4];

  assign dsor = NW'($unsigned(area_r)) << 1;
  assign dsh  = dsor << cmd.step[2:0];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rem_nxt[k] = rem_r[k];
      q_nxt[k]   = q_r[k];
      if (rem_r[k] >= dsh) begin
        rem_nxt[k] = rem_r[k] - dsh;
        q_nxt[k][cmd.step[2:0]] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (cmd.div_init) begin
        rem_r[k] <= (NW'(n_r[k]) << 1) + NW'($unsigned(area_r));
        q_r[k]   <= '0;
      end else if (cmd.div_en) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
    end
  end

  logic [COLW-1:0] mem_q, blend_px;

  always_comb begin
    logic [15:0] mix;
    logic [16:0] yv;
    logic [16:0] qv;
    blend_px = {8'hFF, 24'h0};
    for (int k = 0; k < 3; k++) begin
      mix = 16'(mem_q[8*k +: 8]) * 16'(8'd255 - q_r[3]) + 16'(q_r[k]) * 16'(q_r[3]);
      yv  = 17'(mix) + 17'd127;
      qv  = (yv + (yv >> 8) + 17'd1) >> 8;
      blend_px[8*k +: 8] = qv[7:0];
    end
  end

  logic [COLW-1:0] mem [DEPTH];
  logic [RW-1:0]   caddr_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   waddr, raddr;
  logic [COLW-1:0] wdata;

  assign mem_we = cmd.clr_wr || cmd.px_write;
  assign mem_re = cmd.rd_issue || cmd.px_read;
  assign waddr  = cmd.clr_wr ? AW'(caddr_r) : addr_r;
  assign wdata  = cmd.clr_wr ? '0 : blend_px;
  assign raddr  = cmd.rd_issue ? AW'(idx_r) : addr_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) mem_q <= mem[raddr];
  end

  logic            rd_ok_r;
  logic [CNTW-1:0] drawn_r;

  always_ff @(posedge clk) begin
    if (cmd.clr_init) caddr_r <= '0;
    else if (cmd.clr_wr) caddr_r <= caddr_r + RW'(1);
    if (cmd.rd_issue) rd_ok_r <= RW'(idx_r) < npix;
    if (cmd.load) drawn_r <= '0;
    else if (cmd.px_write) drawn_r <= drawn_r + CNTW'(1);
  end

  function automatic logic passes(input logic signed [EW-1:0] e, input logic tl);
    return (e > 0) || (e == 0 && tl);
  endfunction

  assign stat.op_clear  = (op_r == OP_CLEAR);
  assign stat.op_draw   = (op_r == OP_DRAW);
  assign stat.op_read   = (op_r == OP_READ);
  assign stat.clr_empty = (npix == '0);
  assign stat.clr_last  = (caddr_r == npix - RW'(1));
  assign stat.area_zero = (area_r == '0);
  assign stat.area_neg  = area_r[EW-1];
  assign stat.box_empty = (x0c > x1c) || (y0c > y1c);
  assign stat.covered   = passes(e_r[0], tl1) && passes(e_r[1], tl2) && passes(e_r[2], tl3);
  assign stat.x_last    = (x_r == x1_r);
  assign stat.y_last    = (y_r == y1_r);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_pixel_value  <= (stat.op_read && rd_ok_r) ? mem_q : '0;
      out_pixels_drawn <= drawn_r;
      out_degenerate   <= stat.op_draw && stat.area_zero;
    end
  end

endmodule

/* hdl/triangle_raster_alpha_blend.sv */
// Triangle rasterizer with alpha blending into an on-chip ARGB frame store.
// Input channel (in_valid/in_ready) takes one operation: clear, draw, read.
// Every operation gives exactly one result on the out_valid/out_ready channel.
// Configuration: cfg_we with cfg_index 0 (width) or 1 (height), any time idle.
// A clear writes width*height store words, one a cycle; a draw steps through
// every pixel of the clipped bounding box and does more work per covered pixel.
// The per-pixel work is done by one shared multiply-accumulate unit (edge and
// color products) and an 8-step divider for the four channels; each covered
// pixel does one read and one write of the store.
// A zero-area or clockwise triangle finishes right after its setup.
// The result sits in an output register; the next item is taken while it
// waits, and a stalled receiver holds only the finish of the next item.
// Reset restores width 16 and height 8; the frame store is not cleared and
// holds undefined data until a clear or draw writes it.
module triangle_raster_alpha_blend import tra_pkg::*; #(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = MAX_HEIGHT_DEF,
  parameter int SUBPIXEL_BITS = SUBPIXEL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OPW-1:0]       in_operation,
  input  logic signed [VW-1:0] in_vertex_a_x,
  input  logic signed [VW-1:0] in_vertex_a_y,
  input  logic signed [VW-1:0] in_vertex_b_x,
  input  logic signed [VW-1:0] in_vertex_b_y,
  input  logic signed [VW-1:0] in_vertex_c_x,
  input  logic signed [VW-1:0] in_vertex_c_y,
  input  logic [COLW-1:0]      in_vertex_a_color,
  input  logic [COLW-1:0]      in_vertex_b_color,
  input  logic [COLW-1:0]      in_vertex_c_color,
  input  logic [VW-1:0]        in_pixel_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COLW-1:0]      out_pixel_value,
  output logic [CNTW-1:0]      out_pixels_drawn,
  output logic                 out_degenerate
);

  tra_cmd_t  cmd;
  tra_stat_t stat;

  tra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tra_datapath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .SUBPIXEL_BITS (SUBPIXEL_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_operation      (in_operation),
    .in_vertex_a_x     (in_vertex_a_x),
    .in_vertex_a_y     (in_vertex_a_y),
    .in_vertex_b_x     (in_vertex_b_x),
    .in_vertex_b_y     (in_vertex_b_y),
    .in_vertex_c_x     (in_vertex_c_x),
    .in_vertex_c_y     (in_vertex_c_y),
    .in_vertex_a_color (in_vertex_a_color),
    .in_vertex_b_color (in_vertex_b_color),
    .in_vertex_c_color (in_vertex_c_color),
    .in_pixel_index    (in_pixel_index),
    .cmd               (cmd),
    .stat              (stat),
    .out_pixel_value   (out_pixel_value),
    .out_pixels_drawn  (out_pixels_drawn),
    .out_degenerate    (out_degenerate)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transfer");

  a_write_covered: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.px_write |-> stat.covered && stat.op_draw)
    else $error("store write for a pixel that is not covered");

  a_degen_no_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_pixels_drawn == 13'd0)
    else $error("degenerate draw reports blended pixels");

  a_read_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pixel_value != 32'd0) |-> !out_degenerate && out_pixels_drawn == 13'd0)
    else $error("pixel value mixed with draw results");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
  import tra_pkg::*;

  localparam logic [OPW-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1850;
  localparam longint CYCLE_LIMIT = 40_000_000;

  typedef struct {
    logic [OPW-1:0] op;
    logic signed [VW-1:0] ax, ay, bx, by, cx, cy;
    logic [COLW-1:0] ca, cb, cc;
    logic [VW-1:0] idx;
  } raster_req_t;

  typedef struct {
    logic [COLW-1:0] pix;
    logic [CNTW-1:0] drawn;
    logic degen;
  } raster_res_t;

  typedef struct {
    raster_req_t req;
    bit typed;
    raster_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OPW-1:0] in_operation = '0;
  logic signed [VW-1:0] in_vertex_a_x = '0, in_vertex_a_y = '0;
  logic signed [VW-1:0] in_vertex_b_x = '0, in_vertex_b_y = '0;
  logic signed [VW-1:0] in_vertex_c_x = '0, in_vertex_c_y = '0;
  logic [COLW-1:0] in_vertex_a_color = '0, in_vertex_b_color = '0, in_vertex_c_color = '0;
  logic [VW-1:0] in_pixel_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COLW-1:0] out_pixel_value;
  logic [CNTW-1:0] out_pixels_drawn;
  logic out_degenerate;

  triangle_raster_alpha_blend DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_vertex_a_x(in_vertex_a_x), .in_vertex_a_y(in_vertex_a_y),
    .in_vertex_b_x(in_vertex_b_x), .in_vertex_b_y(in_vertex_b_y),
    .in_vertex_c_x(in_vertex_c_x), .in_vertex_c_y(in_vertex_c_y),
    .in_vertex_a_color(in_vertex_a_color), .in_vertex_b_color(in_vertex_b_color),
    .in_vertex_c_color(in_vertex_c_color), .in_pixel_index(in_pixel_index),
    .out_valid(out_valid), .out_ready(out_ready), .out_pixel_value(out_pixel_value),
    .out_pixels_drawn(out_pixels_drawn), .out_degenerate(out_degenerate)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [COLW-1:0] frame_mem [0:4095];
  bit written [0:4095];
  logic [PXW-1:0] img_w = IMAGE_WIDTH_RST;
  logic [PXW-1:0] img_h = IMAGE_HEIGHT_RST;
  raster_res_t result_q [$];
  int mismatches = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  longint cycles = 0;

  function automatic longint eff_w();
    return (img_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : img_w;
  endfunction

  function automatic longint eff_h();
    return (img_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : img_h;
  endfunction

  function automatic longint edge_val(longint px, longint py, longint qx, longint qy,
                                      longint sx, longint sy);
    return (qx - px) * (sy - py) - (qy - py) * (sx - px);
  endfunction

  function automatic bit is_top_left(longint px, longint py, longint qx, longint qy);
    return (qy - py < 0) || ((qy - py == 0) && (qx - px > 0));
  endfunction

  function automatic longint min3(longint a, longint b, longint c);
    longint m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic longint max3(longint a, longint b, longint c);
    longint m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic longint byte_of(logic [COLW-1:0] c, int sh);
    return longint'((c >> sh) & 32'hFF);
  endfunction

  function automatic raster_res_t raster_predict(raster_req_t r);
    raster_res_t o;
    longint w, h, ax, ay, bx, by, cx, cy, area, x0, x1, y0, y1, e1, e2, e3;
    longint al, n, c, old_ch, blended, pidx;
    bit t1, t2, t3;
    logic [COLW-1:0] old, nw;
    w = eff_w();
    h = eff_h();
    o.pix = '0;
    o.drawn = '0;
    o.degen = 1'b0;
    case (r.op)
      OP_CLEAR: begin
        for (int i = 0; i < w * h; i++) begin
          frame_mem[i] = '0;
          written[i] = 1'b1;
        end
      end
      OP_READ: begin
        if (r.idx < w * h) o.pix = frame_mem[r.idx];
      end
      OP_DRAW: begin
        ax = r.ax; ay = r.ay; bx = r.bx; by = r.by; cx = r.cx; cy = r.cy;
        area = edge_val(ax, ay, bx, by, cx, cy);
        if (area == 0) begin
          o.degen = 1'b1;
        end else if (w > 0 && h > 0) begin
          t1 = is_top_left(ax, ay, bx, by);
          t2 = is_top_left(bx, by, cx, cy);
          t3 = is_top_left(cx, cy, ax, ay);
          x0 = min3(ax, bx, cx) >>> SUBPIXEL_BITS_DEF;
          x1 = max3(ax, bx, cx) >>> SUBPIXEL_BITS_DEF;
          y0 = min3(ay, by, cy) >>> SUBPIXEL_BITS_DEF;
          y1 = max3(ay, by, cy) >>> SUBPIXEL_BITS_DEF;
          if (x0 < 0) x0 = 0;
          if (y0 < 0) y0 = 0;
          if (x1 > w - 1) x1 = w - 1;
          if (y1 > h - 1) y1 = h - 1;
          for (longint y = y0; y <= y1; y++) begin
            for (longint x = x0; x <= x1; x++) begin
              e1 = edge_val(ax, ay, bx, by, x * 16, y * 16);
              e2 = edge_val(bx, by, cx, cy, x * 16, y * 16);
              e3 = edge_val(cx, cy, ax, ay, x * 16, y * 16);
              if ((e1 > 0 || (e1 == 0 && t1)) && (e2 > 0 || (e2 == 0 && t2)) &&
                  (e3 > 0 || (e3 == 0 && t3))) begin
                pidx = y * w + x;
                old = frame_mem[pidx];
                n = byte_of(r.ca, 24) * e2 + byte_of(r.cb, 24) * e3 + byte_of(r.cc, 24) * e1;
                al = (2 * n + area) / (2 * area);
                nw = 32'hFF000000;
                for (int sh = 0; sh < 24; sh += 8) begin
                  n = byte_of(r.ca, sh) * e2 + byte_of(r.cb, sh) * e3 + byte_of(r.cc, sh) * e1;
                  c = (2 * n + area) / (2 * area);
                  old_ch = byte_of(old, sh);
                  blended = (2 * (old_ch * (255 - al) + c * al) + 255) / 510;
                  nw = nw | (COLW'(blended & 8'hFF) << sh);
                end
                frame_mem[pidx] = nw;
                written[pidx] = 1'b1;
                o.drawn = o.drawn + 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    raster_res_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected transfer", out_pixel_value, 0);
      end else begin
        want = result_q.pop_front();
        if (out_pixel_value !== want.pix)
          report_mismatch("pixel_value", out_pixel_value, want.pix);
        if (out_pixels_drawn !== want.drawn)
          report_mismatch("pixels_drawn", out_pixels_drawn, want.drawn);
        if (out_degenerate !== want.degen)
          report_mismatch("degenerate", out_degenerate, want.degen);
      end
    end
  end

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= rcv_idle);

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic transfer_item(raster_req_t r, bit typed, raster_res_t t);
    raster_res_t p;
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_operation = r.op;
    in_vertex_a_x = r.ax; in_vertex_a_y = r.ay;
    in_vertex_b_x = r.bx; in_vertex_b_y = r.by;
    in_vertex_c_x = r.cx; in_vertex_c_y = r.cy;
    in_vertex_a_color = r.ca; in_vertex_b_color = r.cb; in_vertex_c_color = r.cc;
    in_pixel_index = r.idx;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    p = raster_predict(r);
    result_q.push_back(typed ? t : p);
    @(negedge clk);
  endtask

  task automatic set_size(int w, int h);
    in_valid = 1'b0;
    wait (result_q.size() == 0);
    repeat (40) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = CFG_DW'(w);
    @(negedge clk);
    cfg_index = REG_IMAGE_HEIGHT;
    cfg_data = CFG_DW'(h);
    @(negedge clk);
    cfg_we = 1'b0;
    img_w = PXW'(w);
    img_h = PXW'(h);
  endtask

  function automatic raster_req_t blank_req(logic [OPW-1:0] op);
    raster_req_t r;
    r.op = op;
    r.ax = VW'($urandom); r.ay = VW'($urandom);
    r.bx = VW'($urandom); r.by = VW'($urandom);
    r.cx = VW'($urandom); r.cy = VW'($urandom);
    r.ca = $urandom; r.cb = $urandom; r.cc = $urandom;
    r.idx = VW'($urandom);
    return r;
  endfunction

  function automatic logic [COLW-1:0] rand_color();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic raster_req_t rand_req();
    raster_req_t r;
    int k, sel, px, py, span;
    longint wh, id;
    bit found;
    sel = $urandom_range(99);
    if (sel < 52) begin
      r = blank_req(OP_DRAW);
      r.ca = rand_color(); r.cb = rand_color(); r.cc = rand_color();
      if ($urandom_range(199) != 0) begin
        px = $urandom_range(eff_w() + 3) - 2;
        py = $urandom_range(eff_h() + 3) - 2;
        span = $urandom_range(6, 1) * 16;
        r.ax = VW'(px * 16 + $urandom_range(2 * span) - span);
        r.ay = VW'(py * 16 + $urandom_range(2 * span) - span);
        r.bx = VW'(px * 16 + $urandom_range(2 * span) - span);
        r.by = VW'(py * 16 + $urandom_range(2 * span) - span);
        r.cx = VW'(px * 16 + $urandom_range(2 * span) - span);
        r.cy = VW'(py * 16 + $urandom_range(2 * span) - span);
        if ($urandom_range(19) == 0) begin
          r.cx = r.ax;
          r.cy = r.ay;
        end
      end
    end else if (sel < 90) begin
      r = blank_req(OP_READ);
      wh = eff_w() * eff_h();
      found = 1'b0;
      if ($urandom_range(3) != 0 && wh > 0) begin
        for (k = 0; k < 8 && !found; k++) begin
          id = $urandom_range(wh - 1);
          if (written[id]) begin
            r.idx = VW'(id);
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        if (wh < 4096) r.idx = VW'($urandom_range(4095, wh));
        else r.op = OP_CLEAR;
      end
    end else if (sel < 97) begin
      r = blank_req(OP_CLEAR);
    end else begin
      r = blank_req(OP_UNUSED);
    end
    return r;
  endfunction

  stim_row_t dir_q [$];

  task automatic add_row(raster_req_t r, bit typed, logic [COLW-1:0] pix,
                         logic [CNTW-1:0] drawn, logic degen);
    stim_row_t s;
    s.req = r;
    s.typed = typed;
    s.res.pix = pix;
    s.res.drawn = drawn;
    s.res.degen = degen;
    dir_q.push_back(s);
  endtask

  initial begin
    raster_req_t r;
    raster_res_t none;
    int sizes [6][2] = '{'{64, 64}, '{1, 1}, '{0, 5}, '{127, 127}, '{100, 3}, '{16, 8}};
    none.pix = '0; none.drawn = '0; none.degen = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    add_row(blank_req(OP_CLEAR), 1, 0, 0, 0);
    r = blank_req(OP_READ); r.idx = 12'd0;
    add_row(r, 1, 0, 0, 0);
    r = blank_req(OP_READ); r.idx = 12'd4095;
    add_row(r, 1, 0, 0, 0);
    add_row(blank_req(OP_UNUSED), 1, 0, 0, 0);
    r = blank_req(OP_DRAW);
    r.ax = -12'sd2048; r.ay = -12'sd2048; r.bx = r.ax; r.by = r.ay; r.cx = r.ax; r.cy = r.ay;
    add_row(r, 1, 0, 0, 1);
    r = blank_req(OP_DRAW);
    r.ax = 12'sd0; r.ay = 12'sd0; r.bx = 12'sd32; r.by = 12'sd32; r.cx = 12'sd80; r.cy = 12'sd80;
    add_row(r, 1, 0, 0, 1);
    r = blank_req(OP_DRAW);
    r.ax = 12'sd0; r.ay = 12'sd0; r.bx = 12'sd0; r.by = 12'sd64; r.cx = 12'sd64; r.cy = 12'sd0;
    add_row(r, 1, 0, 0, 0);
    r = blank_req(OP_DRAW);
    r.ax = -12'sd2048; r.ay = -12'sd2048; r.bx = -12'sd1024; r.by = -12'sd2048;
    r.cx = -12'sd2048; r.cy = -12'sd1024;
    add_row(r, 1, 0, 0, 0);
    r = blank_req(OP_DRAW);
    r.ax = 12'sd0; r.ay = 12'sd0; r.bx = 12'sd64; r.by = 12'sd0; r.cx = 12'sd0; r.cy = 12'sd64;
    r.ca = 32'hFFFFFFFF; r.cb = 32'hFFFFFFFF; r.cc = 32'hFFFFFFFF;
    add_row(r, 0, 0, 0, 0);
    r = blank_req(OP_DRAW);
    r.ax = -12'sd2048; r.ay = -12'sd2048; r.bx = 12'sd2047; r.by = -12'sd2048;
    r.cx = -12'sd2048; r.cy = 12'sd2047;
    r.ca = 32'h00000000; r.cb = 32'hFFFFFFFF; r.cc = 32'h80FF0000;
    add_row(r, 0, 0, 0, 0);
    r = blank_req(OP_DRAW);
    r.ax = 12'sd24; r.ay = 12'sd8; r.bx = 12'sd2047; r.by = 12'sd8; r.cx = 12'sd24; r.cy = 12'sd2047;
    r.ca = 32'h7F123456; r.cb = 32'h00FFFFFF; r.cc = 32'hFF000000;
    add_row(r, 0, 0, 0, 0);
    foreach (sizes[i]) begin
      r = blank_req(OP_READ);
      r.idx = VW'(i * 23);
      add_row(r, 0, 0, 0, 0);
    end
    r = blank_req(OP_READ); r.idx = 12'd127;
    add_row(r, 0, 0, 0, 0);
    r = blank_req(OP_READ); r.idx = 12'd128;
    add_row(r, 1, 0, 0, 0);

    foreach (dir_q[i]) transfer_item(dir_q[i].req, dir_q[i].typed, dir_q[i].res);

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 22 : (ph == 1) ? 87 : 0;
      rcv_idle = (ph == 0) ? 87 : (ph == 1) ? 22 : 0;
      for (int s = 0; s < 2; s++) begin
        set_size(sizes[ph * 2 + s][0], sizes[ph * 2 + s][1]);
        transfer_item(blank_req(OP_CLEAR), 0, none);
        for (int n = 0; n < RANDOM_ITEMS / 6; n++) transfer_item(rand_req(), 0, none);
        in_valid = 1'b0;
      end
    end

    in_valid = 1'b0;
    wait (result_q.size() == 0);
    repeat (50) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/tra_pkg.sv
hdl/tra_ctrl.sv
hdl/tra_datapath.sv
hdl/triangle_raster_alpha_blend.sv
test/tb.sv
